@@ hdl/deque_indexed_delete_dump_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the deque block
// Concurrent checks, left empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DEQUE_INDEXED_DELETE_DUMP_UNIT_MACROS_SVH
`define DEQUE_INDEXED_DELETE_DUMP_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DQD_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rs) (ante) |-> (cons)) \
    else $error("dqd: same-cycle check failed");
// next-cycle implication
`define DQD_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rs) (ante) |=> (cons)) \
    else $error("dqd: next-cycle check failed");
`else
`define DQD_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define DQD_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif

`endif

@@ hdl/dqd_pkg.sv @@
// ----------------------------------------------------------------------------
// dqd_pkg
// Shared constants, codes and helpers for the deque block.
// ----------------------------------------------------------------------------
package dqd_pkg;

  localparam int CAPACITY_DEF   = 32;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int OPERAND_W      = 32;
  localparam int ELEMENT_W      = 32;
  localparam int IN_USER_W      = 2;
  localparam int OUT_USER_W     = 4;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_DELETE     = 2'd2,
    CMD_KEEP       = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_POS = 2'd2
  } status_t;

  // address width for a store of n entries, never below one bit
  function automatic int addr_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

@@ hdl/dqd_ram.sv @@
// ----------------------------------------------------------------------------
// dqd_ram
// Simple dual-port store: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dqd_ram #(
  parameter int DEPTH = dqd_pkg::CAPACITY_DEF,
  parameter int WIDTH = dqd_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [dqd_pkg::addr_w(DEPTH)-1:0]  waddr,
  input  logic [WIDTH-1:0]                   wdata,
  input  logic                               re,
  input  logic [dqd_pkg::addr_w(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]                   rdata
);
  import dqd_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/deque_indexed_delete_dump_unit.sv @@
// A request is taken only while the block is idle and the read latch is
// drained; the block then applies the command, moves each of the
// count - pos - 1 entries behind a position deleted inside the list one slot
// forward with a read step and a write step, and dumps the list both ways
// (2 * count results, or 2 for an empty list). The single read
// port of the list store sets the dump at one result per cycle while the output
// is not stalled; the output register lets the last result drain while the next request is applied.
// ----------------------------------------------------------------------------
// deque_indexed_delete_dump_unit
// Circular-store deque with push front/back, delete at position, and a
// front-to-back plus back-to-front dump of the list after every request.
// ----------------------------------------------------------------------------
`include "deque_indexed_delete_dump_unit_macros.svh"

module deque_indexed_delete_dump_unit #(
  parameter int CAPACITY   = dqd_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = dqd_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [dqd_pkg::OPERAND_W-1:0]     in_tdata,   // [31:0] operand
  input  logic [dqd_pkg::IN_USER_W-1:0]     in_tuser,   // [1:0] command
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [dqd_pkg::ELEMENT_W-1:0]     out_tdata,  // [31:0] element
  output logic [dqd_pkg::OUT_USER_W-1:0]    out_tuser,  // [0] backward, [1] present,
                                                        // [3:2] status
  output logic                              out_tlast   // pass_end
);
  import dqd_pkg::*;

  localparam int IW = addr_w(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] LAST_SLOT = IW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_CNT   = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SH_RD,
    S_SH_WR,
    S_DUMP
  } state_t;

  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] hd,
                                            input logic [IW-1:0] i);
    logic [IW:0] s;
    s = {1'b0, hd} + {1'b0, i};
    if (s >= (IW+1)'(CAPACITY)) begin
      s = s - (IW+1)'(CAPACITY);
    end
    return s[IW-1:0];
  endfunction

  state_t                 state_r,     state_nxt;
  logic [IW-1:0]          head_r,      head_nxt;
  logic [CW-1:0]          count_r,     count_nxt;
  cmd_t                   cmd_r,       cmd_nxt;
  logic [OPERAND_W-1:0]   opnd_r,      opnd_nxt;
  status_t                status_r,    status_nxt;
  logic [IW-1:0]          idx_r,       idx_nxt;
  logic                   back_r,      back_nxt;
  logic                   hold_v_r,    hold_v_nxt;
  logic                   hold_back_r, hold_back_nxt;
  logic                   hold_pres_r, hold_pres_nxt;
  logic                   hold_last_r, hold_last_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [ELEMENT_W-1:0]   out_data_r,  out_data_nxt;
  logic [OUT_USER_W-1:0]  out_user_r,  out_user_nxt;
  logic                   out_last_r,  out_last_nxt;

  logic                   wr_en;
  logic [IW-1:0]          wr_addr;
  logic [DATA_WIDTH-1:0]  wr_data;
  logic                   rd_en;
  logic [IW-1:0]          rd_addr;
  logic [DATA_WIDTH-1:0]  rd_data;

  logic                   out_take;
  logic                   empty;
  logic                   pass_last;
  logic [IW-1:0]          head_dec;
  logic [IW-1:0]          head_inc;

  dqd_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign in_tready = (state_r == S_IDLE) && !hold_v_r;
  assign out_take  = !out_valid_r || out_tready;
  assign empty     = (count_r == '0);
  assign head_dec  = (head_r == '0) ? LAST_SLOT : head_r - IW'(1);
  assign head_inc  = (head_r == LAST_SLOT) ? '0 : head_r + IW'(1);
  assign pass_last = empty || (back_r ? (idx_r == '0)
                                      : (CW'(idx_r) == count_r - CW'(1)));

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    cmd_nxt       = cmd_r;
    opnd_nxt      = opnd_r;
    status_nxt    = status_r;
    idx_nxt       = idx_r;
    back_nxt      = back_r;
    hold_v_nxt    = hold_v_r && !out_take;
    hold_back_nxt = hold_back_r;
    hold_pres_nxt = hold_pres_r;
    hold_last_nxt = hold_last_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;
    wr_en         = 1'b0;
    wr_addr       = head_dec;
    wr_data       = DATA_WIDTH'(opnd_r);
    rd_en         = 1'b0;
    rd_addr       = slot_of(head_r, idx_r);

    // output register refills from the read latch
    if (out_take) begin
      out_valid_nxt = hold_v_r;
      if (hold_v_r) begin
        out_data_nxt = hold_pres_r ? ELEMENT_W'($signed(rd_data)) : '0;
        out_user_nxt = {status_r, hold_pres_r, hold_back_r};
        out_last_nxt = hold_last_r;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd_nxt   = cmd_t'(in_tuser);
          opnd_nxt  = in_tdata;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        status_nxt = ST_DONE;
        idx_nxt    = '0;
        back_nxt   = 1'b0;
        state_nxt  = S_DUMP;
        case (cmd_r)
          CMD_PUSH_FRONT: begin
            if (count_r == CAP_CNT) begin
              status_nxt = ST_FULL;
            end else begin
              head_nxt  = head_dec;
              wr_en     = 1'b1;
              wr_addr   = head_dec;
              count_nxt = count_r + CW'(1);
            end
          end
          CMD_PUSH_BACK: begin
            if (count_r == CAP_CNT) begin
              status_nxt = ST_FULL;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = slot_of(head_r, IW'(count_r));
              count_nxt = count_r + CW'(1);
            end
          end
          CMD_DELETE: begin
            // negative positions are huge when read unsigned
            if (opnd_r >= OPERAND_W'(count_r)) begin
              status_nxt = ST_BAD_POS;
            end else if (opnd_r == '0) begin
              head_nxt  = head_inc;
              count_nxt = count_r - CW'(1);
            end else if (CW'(IW'(opnd_r)) + CW'(1) < count_r) begin
              idx_nxt   = IW'(opnd_r);
              state_nxt = S_SH_RD;
            end else begin
              count_nxt = count_r - CW'(1);
            end
          end
          CMD_KEEP: begin
          end
          default: begin
          end
        endcase
      end
      S_SH_RD: begin
        rd_en     = 1'b1;
        rd_addr   = slot_of(head_r, idx_r + IW'(1));
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        // close the gap one entry at a time: slot(i) <= slot(i+1)
        wr_en   = 1'b1;
        wr_addr = slot_of(head_r, idx_r);
        wr_data = rd_data;
        if (CW'(idx_r) + CW'(2) < count_r) begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = S_SH_RD;
        end else begin
          count_nxt = count_r - CW'(1);
          idx_nxt   = '0;
          back_nxt  = 1'b0;
          state_nxt = S_DUMP;
        end
      end
      S_DUMP: begin
        // issue only when the latch will be free next cycle
        if (!hold_v_r || out_take) begin
          rd_en         = !empty;
          hold_v_nxt    = 1'b1;
          hold_back_nxt = back_r;
          hold_pres_nxt = !empty;
          hold_last_nxt = pass_last;
          if (pass_last) begin
            if (!back_r) begin
              back_nxt = 1'b1;
              idx_nxt  = empty ? '0 : IW'(count_r - CW'(1));
            end else begin
              idx_nxt   = '0;
              state_nxt = S_IDLE;
            end
          end else begin
            idx_nxt = back_r ? idx_r - IW'(1) : idx_r + IW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      back_r      <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      back_r      <= back_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r       <= cmd_nxt;
    opnd_r      <= opnd_nxt;
    status_r    <= status_nxt;
    hold_back_r <= hold_back_nxt;
    hold_pres_r <= hold_pres_nxt;
    hold_last_r <= hold_last_nxt;
    out_data_r  <= out_data_nxt;
    out_user_r  <= out_user_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  `DQD_ASSERT_IMP(a_ptr_range, clk, rst_n, 1'b1, count_r <= CAP_CNT && head_r <= LAST_SLOT)
  `DQD_ASSERT_IMP(a_no_clobber, clk, rst_n, hold_v_r && !out_take, !rd_en)
  `DQD_ASSERT_IMP(a_no_write_in_dump, clk, rst_n, state_r == S_DUMP, !wr_en)
  `DQD_ASSERT_NXT(a_push_grows, clk, rst_n, state_r == S_EXEC && cmd_r == CMD_PUSH_BACK && count_r != CAP_CNT, count_r == $past(count_r) + CW'(1))

endmodule
